// File: rtl/core/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared sizes, operation codes and channel types of the key/value table.
// ----------------------------------------------------------------------------
package kvt_pkg;

	// table sizes
	localparam int DEPTH       = 64;
	localparam int KEY_WIDTH   = 32;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int POS_W       = 6;
	localparam int OP_W        = 3;
	localparam int CAP_W       = 7;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 3'd0,
		OP_UPDATE = 3'd1,
		OP_UPSERT = 3'd2,
		OP_ERASE  = 3'd3,
		OP_LOOKUP = 3'd4,
		OP_READ   = 3'd5
	} kvt_op_t;

	// one request beat
	typedef struct packed {
		logic [OP_W-1:0]        op;
		logic [KEY_WIDTH-1:0]   key;
		logic [VALUE_WIDTH-1:0] value;
		logic [POS_W-1:0]       position;
	} kvt_req_t;

	// one result beat
	typedef struct packed {
		logic                   ok;
		logic [KEY_WIDTH-1:0]   found_key;
		logic [VALUE_WIDTH-1:0] found_value;
		logic [CNT_W-1:0]       entry_count;
	} kvt_result_t;

endpackage

// File: rtl/core/kvt_engine.sv
// ----------------------------------------------------------------------------
// kvt_engine
// Key and value memories with the sequencer that scans, reads, modifies and
// writes them back, plus the result register.
// ----------------------------------------------------------------------------
module kvt_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [kvt_pkg::CAP_W-1:0] capacity,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  kvt_pkg::kvt_req_t         req,
	output logic                      out_valid,
	input  logic                      out_ready,
	output kvt_pkg::kvt_result_t      result
);
	import kvt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_EXEC,
		ST_FETCH,
		ST_DONE
	} state_t;

	state_t                 state_q;
	kvt_req_t               req_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       scan_q;
	logic                   chk_s1;
	logic [IDX_W-1:0]       chk_idx_s1;
	logic                   hit_q;
	logic [IDX_W-1:0]       hit_idx_q;
	logic                   res_ok_q;
	logic [KEY_WIDTH-1:0]   res_key_q;
	logic [VALUE_WIDTH-1:0] res_val_q;
	logic                   out_valid_q;
	kvt_result_t            result_q;

	// memories
	logic [KEY_WIDTH-1:0]   key_mem [DEPTH];
	logic [VALUE_WIDTH-1:0] val_mem [DEPTH];
	logic [KEY_WIDTH-1:0]   key_rd_q;
	logic [VALUE_WIDTH-1:0] val_rd_q;

	logic                   scan_issue;
	logic                   match;
	logic                   can_append;
	logic                   do_append;
	logic                   do_update;
	logic                   pos_in_range;
	logic                   needs_search;
	logic                   res_load;
	logic [CNT_W-1:0]       count_m1;
	logic [IDX_W-1:0]       exec_addr;
	logic [IDX_W-1:0]       key_raddr;
	logic                   key_we;
	logic                   val_we;
	logic [IDX_W-1:0]       waddr;
	logic [KEY_WIDTH-1:0]   key_wd;
	logic [VALUE_WIDTH-1:0] val_wd;

	// scan and decision terms
	assign scan_issue   = (scan_q < count_q);
	assign match        = chk_s1 && (key_rd_q == req_q.key);
	assign can_append   = !hit_q && (count_q < capacity) && (count_q < CNT_W'(DEPTH));
	assign pos_in_range = (CNT_W'(req_q.position) < count_q);
	assign count_m1     = count_q - CNT_W'(1);
	assign needs_search = (req.op == OP_INSERT) || (req.op == OP_UPDATE) ||
		(req.op == OP_UPSERT) || (req.op == OP_ERASE) || (req.op == OP_LOOKUP);
	assign do_append    = (state_q == ST_EXEC) && can_append &&
		((req_q.op == OP_INSERT) || (req_q.op == OP_UPSERT));
	assign do_update    = (state_q == ST_EXEC) && hit_q &&
		((req_q.op == OP_UPDATE) || (req_q.op == OP_UPSERT));
	assign res_load     = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// read address of the single read after the scan
	always_comb begin
		case (req_q.op)
			OP_ERASE: exec_addr = count_m1[IDX_W-1:0];
			OP_READ:  exec_addr = IDX_W'(req_q.position);
			default:  exec_addr = hit_idx_q;
		endcase
	end

	assign key_raddr = (state_q == ST_SEARCH) ? scan_q[IDX_W-1:0] : exec_addr;

	// write-back: append or update after the scan, last entry moved on erase
	assign key_we = do_append || ((state_q == ST_FETCH) && (req_q.op == OP_ERASE));
	assign val_we = key_we || do_update;
	assign waddr  = do_append ? count_q[IDX_W-1:0] : hit_idx_q;
	assign key_wd = (state_q == ST_FETCH) ? key_rd_q : req_q.key;
	assign val_wd = (state_q == ST_FETCH) ? val_rd_q : req_q.value;

	// key memory
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[waddr] <= key_wd;
		end
		key_rd_q <= key_mem[key_raddr];
	end

	// value memory
	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[waddr] <= val_wd;
		end
		val_rd_q <= val_mem[exec_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			chk_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// result register: loaded from the done state, cleared once taken
			if (res_load) begin
				out_valid_q          <= 1'b1;
				result_q.ok          <= res_ok_q;
				result_q.found_key   <= res_key_q;
				result_q.found_value <= res_val_q;
				result_q.entry_count <= count_q;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_q  <= req;
						scan_q <= '0;
						chk_s1 <= 1'b0;
						hit_q  <= 1'b0;
						state_q <= needs_search ? ST_SEARCH : ST_EXEC;
					end
				end
				ST_SEARCH: begin
					chk_s1     <= scan_issue && !match;
					chk_idx_s1 <= scan_q[IDX_W-1:0];
					if (scan_issue) begin
						scan_q <= scan_q + CNT_W'(1);
					end
					if (match) begin
						hit_q     <= 1'b1;
						hit_idx_q <= chk_idx_s1;
						state_q   <= ST_EXEC;
					end else if (!scan_issue && !chk_s1) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					res_key_q <= '0;
					res_val_q <= '0;
					case (req_q.op)
						OP_INSERT, OP_UPSERT: begin
							state_q <= ST_DONE;
							if (hit_q && (req_q.op == OP_UPSERT)) begin
								res_ok_q <= 1'b1;
							end else if (can_append) begin
								count_q  <= count_q + CNT_W'(1);
								res_ok_q <= 1'b1;
							end else begin
								res_ok_q <= 1'b0;
							end
						end
						OP_UPDATE: begin
							state_q  <= ST_DONE;
							res_ok_q <= hit_q;
						end
						OP_ERASE, OP_LOOKUP: begin
							state_q  <= hit_q ? ST_FETCH : ST_DONE;
							res_ok_q <= 1'b0;
						end
						OP_READ: begin
							state_q  <= pos_in_range ? ST_FETCH : ST_DONE;
							res_ok_q <= 1'b0;
						end
						default: begin
							state_q  <= ST_DONE;
							res_ok_q <= 1'b0;
						end
					endcase
				end
				ST_FETCH: begin
					state_q <= ST_DONE;
					case (req_q.op)
						OP_ERASE: begin
							res_ok_q <= 1'b1;
							count_q  <= count_m1;
						end
						OP_LOOKUP: begin
							res_ok_q  <= 1'b1;
							res_val_q <= val_rd_q;
						end
						OP_READ: begin
							res_ok_q  <= 1'b1;
							res_key_q <= key_rd_q;
							res_val_q <= val_rd_q;
						end
						default: begin
							res_ok_q <= 1'b0;
						end
					endcase
				end
				ST_DONE: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign result    = result_q;

	// the table never holds more than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above table depth");

	// the scan pointer never runs past the filled entries
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (scan_q <= count_q))
		else $error("scan pointer past entry count");

	// count moves only while an operation is applied
	a_count_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_EXEC && state_q != ST_FETCH) |=> $stable(count_q))
		else $error("entry count changed outside execute");

	// a hit always points inside the filled region
	a_hit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && hit_q) |-> (CNT_W'(hit_idx_q) < count_q))
		else $error("hit index outside filled entries");

	// a result beat is raised only from the done state
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result raised outside done state");

endmodule

// File: rtl/core/key_value_table_core.sv
// ----------------------------------------------------------------------------
// key_value_table_core
// Unsorted key/value table with linear search and an APB capacity register.
// ----------------------------------------------------------------------------
// The table keeps unique key/value pairs packed in entries 0 to count-1 of a
// key memory and a value memory. Each request beat carries one of insert,
// update, insert-or-update, erase, lookup by key or read by position, and
// gives exactly one result beat with a success flag, the found key and value
// and the entry count after the operation. A request is shortest for an
// undefined op or a read past the count, which skip the scan, and longest
// for a miss, or a hit on the last entry, of a full table: the key memory
// is scanned one entry per cycle through its single read port, followed by
// at most one read and one write-back.
// One request is in flight at a time; the next one is taken while the last
// result still waits on the output. Capacity (register 0, reset 64) caps the
// count; values above the depth act as the depth. Memory contents need no
// clearing after reset, so requests are taken at once.
module key_value_table_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [2:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	// requests
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [kvt_pkg::OP_W-1:0]        op,
	input  logic [kvt_pkg::KEY_WIDTH-1:0]   key,
	input  logic [kvt_pkg::VALUE_WIDTH-1:0] value,
	input  logic [kvt_pkg::POS_W-1:0]       position,
	// results
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            ok,
	output logic [kvt_pkg::KEY_WIDTH-1:0]   found_key,
	output logic [kvt_pkg::VALUE_WIDTH-1:0] found_value,
	output logic [kvt_pkg::CNT_W-1:0]       entry_count
);
	import kvt_pkg::*;

	localparam logic REG_CAPACITY = 1'b0;
	localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(64);

	logic [CAP_W-1:0] capacity_q;
	logic             cfg_write;
	kvt_req_t         req;
	kvt_result_t      result;

	// register write on the access phase
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_write && (paddr[2] == REG_CAPACITY)) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	// register read
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_CAPACITY) begin
			prdata = 32'(capacity_q);
		end
	end

	// request beat
	assign req.op       = op;
	assign req.key      = key;
	assign req.value    = value;
	assign req.position = position;

	kvt_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.capacity  (capacity_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req       (req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result)
	);

	// result beat
	assign ok          = result.ok;
	assign found_key   = result.found_key;
	assign found_value = result.found_value;
	assign entry_count = result.entry_count;

endmodule

// File: tb/tb_key_value_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_value_table_core
// Self-checking regression for the unsorted key/value table core.
// ----------------------------------------------------------------------------
// A queue of pending requests feeds a clocked driver that holds each beat
// until it is taken. A clocked monitor runs every taken request through a
// shadow table to work out the result beat it must cause, and compares each
// result beat, field by field, with the oldest outstanding prediction. The run
// starts with a directed sweep of every operation and corner case, then moves
// through random traffic under a series of capacity settings; between settings
// all requests and results drain before the capacity register is rewritten.
module tb_key_value_table_core;

	import kvt_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int REG_CAPACITY = 0;
	localparam logic [2:0] CAPACITY_ADDR = 3'(4 * REG_CAPACITY);
	localparam int KEY_POOL_SIZE = 96;

	// op codes that the table does not define
	localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

	typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} traffic_mix_t;

	logic                   clk         = 1'b0;
	logic                   arst_n      = 1'b0;
	logic                   psel        = 1'b0;
	logic                   penable     = 1'b0;
	logic                   pwrite      = 1'b0;
	logic [2:0]             paddr       = '0;
	logic [31:0]            pwdata      = '0;
	logic [31:0]            prdata;
	logic                   pready;
	logic                   in_valid    = 1'b0;
	logic                   in_ready;
	logic [OP_W-1:0]        op          = '0;
	logic [KEY_WIDTH-1:0]   key         = '0;
	logic [VALUE_WIDTH-1:0] value       = '0;
	logic [POS_W-1:0]       position    = '0;
	logic                   out_valid;
	logic                   out_ready   = 1'b0;
	logic                   ok;
	logic [KEY_WIDTH-1:0]   found_key;
	logic [VALUE_WIDTH-1:0] found_value;
	logic [CNT_W-1:0]       entry_count;

	// shadow copy of the table and its capacity
	logic [KEY_WIDTH-1:0]   shadow_key [DEPTH];
	logic [VALUE_WIDTH-1:0] shadow_val [DEPTH];
	int                     shadow_count = 0;
	int                     cap_limit    = DEPTH;
	int                     filled_mark  = 0;

	kvt_req_t    pending_reqs[$];
	kvt_result_t predicted_results[$];
	kvt_req_t    next_req;
	kvt_req_t    taken_req;
	kvt_result_t want_res;

	logic [KEY_WIDTH-1:0] key_pool [KEY_POOL_SIZE];

	int req_issued     = 0;
	int req_accepted   = 0;
	int send_gap       = 0;
	int stall_left     = 0;
	int mismatch_count = 0;
	int cycle_count    = 0;
	bit steady_flow    = 1'b0;

	key_value_table_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.key         (key),
		.value       (value),
		.position    (position),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.ok          (ok),
		.found_key   (found_key),
		.found_value (found_value),
		.entry_count (entry_count)
	);

	always #6 clk = ~clk;

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady_flow || r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// operation mix for the random traffic
	function automatic logic [OP_W-1:0] pick_op(traffic_mix_t mix);
		int r;
		int cut [6];
		r = $urandom_range(0, 99);
		case (mix)
			MIX_FILL:     cut = '{40, 60, 68, 76, 88, 98};
			MIX_BALANCED: cut = '{22, 36, 48, 66, 82, 98};
			default:      cut = '{12, 20, 30, 65, 80, 98};
		endcase
		if (r < cut[0])
			return OP_INSERT;
		else if (r < cut[1])
			return OP_UPSERT;
		else if (r < cut[2])
			return OP_UPDATE;
		else if (r < cut[3])
			return OP_ERASE;
		else if (r < cut[4])
			return OP_LOOKUP;
		else if (r < cut[5])
			return OP_READ;
		else
			return r[0] ? OP_RSVD6 : OP_RSVD7;
	endfunction

	// apply one request to the shadow table and give the result it causes
	function automatic kvt_result_t apply_request(kvt_req_t rq);
		kvt_result_t res;
		int          hit_idx;
		int          i;
		res     = '0;
		hit_idx = -1;
		for (i = 0; i < shadow_count; i++)
			if (hit_idx < 0 && shadow_key[i] == rq.key)
				hit_idx = i;
		case (rq.op)
			OP_INSERT, OP_UPSERT: begin
				if (hit_idx >= 0) begin
					if (rq.op == OP_UPSERT) begin
						shadow_val[hit_idx] = rq.value;
						res.ok = 1'b1;
					end
				end else if (shadow_count < cap_limit) begin
					shadow_key[shadow_count] = rq.key;
					shadow_val[shadow_count] = rq.value;
					shadow_count++;
					if (shadow_count > filled_mark)
						filled_mark = shadow_count;
					res.ok = 1'b1;
				end
			end
			OP_UPDATE: begin
				if (hit_idx >= 0) begin
					shadow_val[hit_idx] = rq.value;
					res.ok = 1'b1;
				end
			end
			OP_ERASE: begin
				// last entry fills the freed slot
				if (hit_idx >= 0) begin
					shadow_key[hit_idx] = shadow_key[shadow_count-1];
					shadow_val[hit_idx] = shadow_val[shadow_count-1];
					shadow_count--;
					res.ok = 1'b1;
				end
			end
			OP_LOOKUP: begin
				if (hit_idx >= 0) begin
					res.found_value = shadow_val[hit_idx];
					res.ok          = 1'b1;
				end
			end
			OP_READ: begin
				if (rq.position < shadow_count) begin
					res.found_key   = shadow_key[rq.position];
					res.found_value = shadow_val[rq.position];
					res.ok          = 1'b1;
				end
			end
			default: ;
		endcase
		res.entry_count = CNT_W'(shadow_count);
		return res;
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// request driver: one beat held until taken, then an optional gap
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && req_accepted != req_issued) begin
				// beat still waiting
			end else if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap = send_gap - 1;
			end else if (pending_reqs.size() > 0) begin
				next_req = pending_reqs.pop_front();
				op       <= next_req.op;
				key      <= next_req.key;
				value    <= next_req.value;
				position <= next_req.position;
				in_valid <= 1'b1;
				req_issued = req_issued + 1;
				send_gap   = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left = stall_left - 1;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 99) < 15)
					stall_left = pick_gap();
			end
		end
	end

	// monitor: check result beats, then predict for request beats
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (predicted_results.size() == 0) begin
					mismatch_count++;
					$display("%0t: result beat with nothing outstanding, got ok=%0b count=%0d",
						$time, ok, entry_count);
				end else begin
					want_res = predicted_results.pop_front();
					check_field("ok", 64'(want_res.ok), 64'(ok));
					check_field("found_key", 64'(want_res.found_key), 64'(found_key));
					check_field("found_value", 64'(want_res.found_value),
						64'(found_value));
					check_field("entry_count", 64'(want_res.entry_count),
						64'(entry_count));
				end
			end
			if (in_valid && in_ready) begin
				taken_req.op       = op;
				taken_req.key      = key;
				taken_req.value    = value;
				taken_req.position = position;
				predicted_results.push_back(apply_request(taken_req));
				req_accepted = req_accepted + 1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("key_value_table_core regression: fail");
			$finish;
		end
	end

	task automatic push_req(logic [OP_W-1:0] rq_op, logic [KEY_WIDTH-1:0] rq_key,
		logic [VALUE_WIDTH-1:0] rq_value, logic [POS_W-1:0] rq_pos);
		kvt_req_t rq;
		rq.op       = rq_op;
		rq.key      = rq_key;
		rq.value    = rq_value;
		rq.position = rq_pos;
		pending_reqs.push_back(rq);
	endtask

	// wait until every request is taken and every result has come back
	task automatic wait_drained();
		while (pending_reqs.size() != 0 || req_accepted != req_issued ||
			predicted_results.size() != 0)
			@(posedge clk);
	endtask

	// apb write of the capacity register, setup then access
	task automatic write_capacity(int cap);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CAPACITY_ADDR;
		pwdata  <= 32'(cap);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		cap_limit = (cap & 'h7F) > DEPTH ? DEPTH : (cap & 'h7F);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// drain, set capacity, then stream random requests in small batches
	task automatic run_phase(int cap, int n_items, traffic_mix_t mix, int span, bit steady);
		kvt_req_t rq;
		int       left;
		int       r;
		wait_drained();
		write_capacity(cap);
		steady_flow = steady;
		left        = n_items;
		while (left > 0) begin
			while (pending_reqs.size() >= 4)
				@(posedge clk);
			repeat ((left < 25) ? left : 25) begin
				rq.op = pick_op(mix);
				if (rq.op == OP_READ && filled_mark == 0)
					rq.op = OP_LOOKUP;
				if ($urandom_range(0, 99) < 85)
					rq.key = key_pool[$urandom_range(0, span - 1)];
				else
					rq.key = $urandom;
				r = $urandom_range(0, 19);
				rq.value = (r == 0) ? '0 : (r == 1) ? '1 : VALUE_WIDTH'($urandom);
				// reads stay within entries written at some point
				if (rq.op == OP_READ)
					rq.position = POS_W'($urandom_range(0, filled_mark - 1));
				else
					rq.position = POS_W'($urandom_range(0, DEPTH - 1));
				pending_reqs.push_back(rq);
				left--;
			end
		end
	endtask

	initial begin
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < KEY_POOL_SIZE; i++)
			key_pool[i] = $urandom;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: every operation at reset capacity
		push_req(OP_INSERT, 32'h0000_0000, 32'h0000_0000, 6'h00);
		push_req(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F);
		push_req(OP_INSERT, 32'h1234_5678, 32'hA5A5_A5A5, 6'h00);
		push_req(OP_INSERT, 32'h0000_0000, 32'h0000_0001, 6'h00);
		push_req(OP_UPDATE, 32'h1234_5678, 32'h5A5A_5A5A, 6'h3F);
		push_req(OP_UPDATE, 32'hDEAD_BEEF, 32'h0000_0001, 6'h00);
		push_req(OP_UPSERT, 32'hFFFF_FFFF, 32'h0000_0000, 6'h00);
		push_req(OP_UPSERT, 32'h00C0_FFEE, 32'h0000_0007, 6'h3F);
		push_req(OP_LOOKUP, 32'h1234_5678, 32'h0000_0000, 6'h00);
		push_req(OP_LOOKUP, 32'h0000_0001, 32'h0000_0000, 6'h00);
		push_req(OP_READ,   32'h0000_0000, 32'h0000_0000, 6'd3);
		push_req(OP_ERASE,  32'h0000_0000, 32'h0000_0000, 6'h00);
		push_req(OP_ERASE,  32'h0000_0000, 32'h0000_0000, 6'h00);
		push_req(OP_READ,   32'h0000_0000, 32'h0000_0000, 6'd3);
		push_req(OP_READ,   32'h0000_0000, 32'h0000_0000, 6'd0);
		push_req(OP_RSVD6,  $urandom, $urandom, 6'h3F);
		push_req(OP_RSVD7,  $urandom, $urandom, 6'h00);

		// capacity lowered below the count
		wait_drained();
		write_capacity(1);
		push_req(OP_INSERT, 32'h0BAD_F00D, 32'h0000_0003, 6'h00);
		push_req(OP_UPSERT, 32'h0BAD_F00D, 32'h0000_0003, 6'h00);
		push_req(OP_UPSERT, 32'hFFFF_FFFF, 32'h0000_0011, 6'h00);
		push_req(OP_ERASE,  32'hFFFF_FFFF, 32'h0000_0000, 6'h00);
		push_req(OP_ERASE,  32'h00C0_FFEE, 32'h0000_0000, 6'h00);
		push_req(OP_INSERT, 32'h0BAD_F00D, 32'h0000_0003, 6'h00);

		// capacity zero
		wait_drained();
		write_capacity(0);
		push_req(OP_ERASE,  32'h1234_5678, 32'h0000_0000, 6'h00);
		push_req(OP_INSERT, 32'h0BAD_F00D, 32'h0000_0003, 6'h00);

		// capacity above the depth
		wait_drained();
		write_capacity(127);
		push_req(OP_INSERT, 32'h0BAD_F00D, 32'h0000_0003, 6'h00);

		// random traffic across capacity settings
		run_phase(64,  250, MIX_FILL,     KEY_POOL_SIZE, 1'b0);
		run_phase(127, 150, MIX_BALANCED, KEY_POOL_SIZE, 1'b1);
		run_phase(20,  200, MIX_DRAIN,    30,            1'b0);
		run_phase(1,   100, MIX_BALANCED, 6,             1'b0);
		run_phase(0,    60, MIX_BALANCED, 6,             1'b0);
		run_phase(65,  150, MIX_FILL,     KEY_POOL_SIZE, 1'b0);
		run_phase($urandom_range(1, 64), 150, MIX_BALANCED, 70, 1'b1);
		run_phase($urandom_range(0, 127), 150, MIX_DRAIN, KEY_POOL_SIZE, 1'b0);
		run_phase(64,  100, MIX_BALANCED, KEY_POOL_SIZE, 1'b0);

		// let any stray beat show up
		wait_drained();
		repeat (100) @(posedge clk);
		if (mismatch_count == 0)
			$display("key_value_table_core regression: pass");
		else
			$display("key_value_table_core regression: fail");
		$finish;
	end

endmodule
